// File: hdl/mes_pkg.sv
// Shared types and constants for the matrix embedding shrinkage block.
package mes_pkg;

    localparam int GROUP_SIZE = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int INDEX_BITS = $clog2(GROUP_SIZE);

    typedef struct packed {
        logic                  multi;
        logic                  shrunk;
        logic [GROUP_SIZE-1:0] chg;
    } mes_job_ctrl_t;

endpackage

// File: hdl/mes_coef_if.sv
// Input channel carrying one coefficient, its tag and its message pair.
interface mes_coef_if #(
    parameter int COEF_BITS = 12,
    parameter int TAG_BITS  = 24
);
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] coef_value;
    logic        [TAG_BITS-1:0]  coef_tag;
    logic        [1:0]           msg_bits;

    modport source (output valid, output coef_value, output coef_tag, output msg_bits,
                    input ready);
    modport sink (input valid, input coef_value, input coef_tag, input msg_bits,
                  output ready);
endinterface

// File: hdl/mes_result_if.sv
// Output channel carrying one embedded coefficient and its flags.
interface mes_result_if #(
    parameter int COEF_BITS = 12,
    parameter int TAG_BITS  = 24
);
    logic                        valid;
    logic                        ready;
    logic signed [COEF_BITS-1:0] out_value;
    logic        [TAG_BITS-1:0]  out_tag;
    logic                        was_changed;
    logic                        shrunk;
    logic                        pair_done;
    logic                        last;

    modport source (output valid, output out_value, output out_tag, output was_changed,
                    output shrunk, output pair_done, output last, input ready);
    modport sink (input valid, input out_value, input out_tag, input was_changed,
                  input shrunk, input pair_done, input last, output ready);
endinterface

// File: hdl/matrix_embed_shrinkage.sv
// The block accepts one coefficient per cycle whenever its two-entry job queue has room,
// and delivers one result per cycle from its output register while jobs are queued and the
// receiver takes them. A zero coefficient or a shrinkage gives a one-result job; a completed
// group of three gives a three-result job that the back end unpacks one result at a time, so
// sustained input rate is one coefficient per cycle while output keeps pace. The first
// result of a job passes through the job queue and then the output register, from which
// it is offered. Held coefficients at the end of a stream are never flushed.
module matrix_embed_shrinkage
    import mes_pkg::*;
#(
    parameter int COEF_BITS = 12,
    parameter int TAG_BITS  = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    mes_coef_if.sink      coef,
    mes_result_if.source  res
);

    logic                                 push;
    logic                                 pop;
    logic                                 queue_full;
    logic                                 queue_empty;
    mes_job_ctrl_t                        push_ctrl;
    logic [GROUP_SIZE-1:0][COEF_BITS-1:0] push_vals;
    logic [GROUP_SIZE-1:0][TAG_BITS-1:0]  push_tags;
    mes_job_ctrl_t                        head_ctrl;
    logic [GROUP_SIZE-1:0][COEF_BITS-1:0] head_vals;
    logic [GROUP_SIZE-1:0][TAG_BITS-1:0]  head_tags;

    mes_front #(
        .COEF_BITS (COEF_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef       (coef),
        .queue_full (queue_full),
        .push       (push),
        .job_ctrl   (push_ctrl),
        .job_vals   (push_vals),
        .job_tags   (push_tags)
    );

    mes_queue #(
        .COEF_BITS (COEF_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ctrl (push_ctrl),
        .push_vals (push_vals),
        .push_tags (push_tags),
        .pop       (pop),
        .full      (queue_full),
        .empty     (queue_empty),
        .head_ctrl (head_ctrl),
        .head_vals (head_vals),
        .head_tags (head_tags)
    );

    mes_back #(
        .COEF_BITS (COEF_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!queue_empty),
        .head_ctrl  (head_ctrl),
        .head_vals  (head_vals),
        .head_tags  (head_tags),
        .pop        (pop),
        .res        (res)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && queue_full))
        else $error("job pushed into a full queue");

    a_push_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !queue_empty)
        else $error("queue empty right after a job push");

    a_shrunk_result: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.shrunk |->
            res.was_changed && res.last && !res.pair_done && res.out_value == '0)
        else $error("shrunk result with inconsistent flags or value");

    a_single_pop: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !queue_empty && (!res.valid || res.ready))
        else $error("job popped without room in the output register");

endmodule

// File: hdl/mes_front.sv
// Front end: accepts coefficients, builds groups and decides the embedding change.
module mes_front
    import mes_pkg::*;
#(
    parameter int COEF_BITS = 12,
    parameter int TAG_BITS  = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    mes_coef_if.sink                              coef,
    input  logic                                  queue_full,
    output logic                                  push,
    output mes_job_ctrl_t                         job_ctrl,
    output logic [GROUP_SIZE-1:0][COEF_BITS-1:0]  job_vals,
    output logic [GROUP_SIZE-1:0][TAG_BITS-1:0]   job_tags
);

    localparam logic [COEF_BITS-1:0] VAL_ONE       = COEF_BITS'(1);
    localparam logic [COEF_BITS-1:0] VAL_MINUS_ONE = '1;

    logic [1:0][COEF_BITS-1:0] held_val_reg, held_val_next;
    logic [1:0][TAG_BITS-1:0]  held_tag_reg, held_tag_next;
    logic [1:0]                held_cnt_reg, held_cnt_next;
    logic [1:0]                pair_reg, pair_next;

    logic                                 accept;
    logic [GROUP_SIZE-1:0][COEF_BITS-1:0] g_val;
    logic [GROUP_SIZE-1:0][TAG_BITS-1:0]  g_tag;
    logic [GROUP_SIZE-1:0][COEF_BITS-1:0] mod_val;
    logic [GROUP_SIZE-1:0]                chg;
    logic [GROUP_SIZE-1:0]                hit;
    logic [1:0]                           syn;
    logic [1:0]                           sel;
    logic                                 shrink;
    logic [TAG_BITS-1:0]                  hit_tag;

    assign coef.ready = !queue_full;
    assign accept     = coef.valid && coef.ready;

    always_comb
    begin
        g_val[0] = held_val_reg[0];
        g_val[1] = held_val_reg[1];
        g_val[2] = coef.coef_value;
        g_tag[0] = held_tag_reg[0];
        g_tag[1] = held_tag_reg[1];
        g_tag[2] = coef.coef_tag;

        syn = {g_val[1][0] ^ g_val[2][0], g_val[0][0] ^ g_val[2][0]};
        sel = syn ^ pair_reg;

        for (int i = 0; i < GROUP_SIZE; i++)
        begin
            chg[i] = (sel == 2'(i + 1));
            if (!chg[i])
            begin
                mod_val[i] = g_val[i];
            end
            else if ($signed(g_val[i]) > 0)
            begin
                mod_val[i] = g_val[i] - VAL_ONE;
            end
            else
            begin
                mod_val[i] = g_val[i] + VAL_ONE;
            end
            hit[i] = chg[i] && (g_val[i] == VAL_ONE || g_val[i] == VAL_MINUS_ONE);
        end
        shrink = |hit;

        case (sel)
            2'd1:    hit_tag = g_tag[0];
            2'd2:    hit_tag = g_tag[1];
            2'd3:    hit_tag = g_tag[2];
            default: hit_tag = g_tag[0];
        endcase
    end

    always_comb
    begin
        held_val_next = held_val_reg;
        held_tag_next = held_tag_reg;
        held_cnt_next = held_cnt_reg;
        pair_next     = pair_reg;
        push          = 1'b0;
        job_ctrl      = '0;
        job_vals      = '0;
        job_tags      = '0;
        job_tags[0]   = coef.coef_tag;

        if (accept)
        begin
            if (coef.coef_value == '0)
            begin
                push = 1'b1;
            end
            else
            begin
                case (held_cnt_reg)
                    2'd0:
                    begin
                        pair_next        = coef.msg_bits;
                        held_val_next[0] = coef.coef_value;
                        held_tag_next[0] = coef.coef_tag;
                        held_cnt_next    = 2'd1;
                    end
                    2'd1:
                    begin
                        held_val_next[1] = coef.coef_value;
                        held_tag_next[1] = coef.coef_tag;
                        held_cnt_next    = 2'd2;
                    end
                    default:
                    begin
                        push = 1'b1;
                        if (shrink)
                        begin
                            job_ctrl.shrunk  = 1'b1;
                            job_ctrl.chg     = GROUP_SIZE'(1);
                            job_tags[0]      = hit_tag;
                            held_val_next[0] = hit[0] ? g_val[1] : g_val[0];
                            held_tag_next[0] = hit[0] ? g_tag[1] : g_tag[0];
                            held_val_next[1] = hit[2] ? g_val[1] : g_val[2];
                            held_tag_next[1] = hit[2] ? g_tag[1] : g_tag[2];
                            held_cnt_next    = 2'd2;
                        end
                        else
                        begin
                            job_ctrl.multi = 1'b1;
                            job_ctrl.chg   = chg;
                            job_vals       = mod_val;
                            job_tags       = g_tag;
                            held_cnt_next  = 2'd0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_cnt_reg <= 2'd0;
            pair_reg     <= 2'd0;
        end
        else
        begin
            held_cnt_reg <= held_cnt_next;
            pair_reg     <= pair_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_val_reg <= held_val_next;
        held_tag_reg <= held_tag_next;
    end

endmodule

// File: hdl/mes_queue.sv
// Short job queue between the front end and the result serializer.
module mes_queue
    import mes_pkg::*;
#(
    parameter int COEF_BITS = 12,
    parameter int TAG_BITS  = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  mes_job_ctrl_t                         push_ctrl,
    input  logic [GROUP_SIZE-1:0][COEF_BITS-1:0]  push_vals,
    input  logic [GROUP_SIZE-1:0][TAG_BITS-1:0]   push_tags,
    input  logic                                  pop,
    output logic                                  full,
    output logic                                  empty,
    output mes_job_ctrl_t                         head_ctrl,
    output logic [GROUP_SIZE-1:0][COEF_BITS-1:0]  head_vals,
    output logic [GROUP_SIZE-1:0][TAG_BITS-1:0]   head_tags
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(QUEUE_DEPTH - 1);

    mes_job_ctrl_t                        ctrl_mem [QUEUE_DEPTH];
    logic [GROUP_SIZE-1:0][COEF_BITS-1:0] val_mem  [QUEUE_DEPTH];
    logic [GROUP_SIZE-1:0][TAG_BITS-1:0]  tag_mem  [QUEUE_DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (cnt_reg == CNT_BITS'(QUEUE_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_ctrl = ctrl_mem[rd_ptr_reg];
    assign head_vals = val_mem[rd_ptr_reg];
    assign head_tags = tag_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctrl_mem[wr_ptr_reg] <= push_ctrl;
            val_mem[wr_ptr_reg]  <= push_vals;
            tag_mem[wr_ptr_reg]  <= push_tags;
        end
    end

endmodule

// File: hdl/mes_back.sv
// Back end: unpacks queued jobs into single results behind an output register.
module mes_back
    import mes_pkg::*;
#(
    parameter int COEF_BITS = 12,
    parameter int TAG_BITS  = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  head_valid,
    input  mes_job_ctrl_t                         head_ctrl,
    input  logic [GROUP_SIZE-1:0][COEF_BITS-1:0]  head_vals,
    input  logic [GROUP_SIZE-1:0][TAG_BITS-1:0]   head_tags,
    output logic                                  pop,
    mes_result_if.source                          res
);

    localparam logic [INDEX_BITS-1:0] LAST_IDX = INDEX_BITS'(GROUP_SIZE - 1);

    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COEF_BITS-1:0]  out_value_reg;
    logic [TAG_BITS-1:0]   out_tag_reg;
    logic                  out_chg_reg;
    logic                  out_shrunk_reg;
    logic                  out_done_reg;
    logic                  out_last_reg;

    logic load;
    logic job_end;

    assign job_end = !head_ctrl.multi || (idx_reg == LAST_IDX);
    assign load    = head_valid && (!out_valid_reg || res.ready);
    assign pop     = load && job_end;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !res.ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = job_end ? '0 : idx_reg + INDEX_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_value_reg  <= head_vals[idx_reg];
            out_tag_reg    <= head_tags[idx_reg];
            out_chg_reg    <= head_ctrl.chg[idx_reg];
            out_shrunk_reg <= head_ctrl.shrunk;
            out_done_reg   <= head_ctrl.multi && job_end;
            out_last_reg   <= job_end;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.out_value   = out_value_reg;
    assign res.out_tag     = out_tag_reg;
    assign res.was_changed = out_chg_reg;
    assign res.shrunk      = out_shrunk_reg;
    assign res.pair_done   = out_done_reg;
    assign res.last        = out_last_reg;

endmodule

// File: bench/tb_matrix_embed_shrinkage.sv
// Self-checking testbench for matrix_embed_shrinkage with an embedded group predictor.
module tb_matrix_embed_shrinkage
    import mes_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COEF_BITS = 12;
    localparam int TAG_BITS = 24;
    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        logic signed [COEF_BITS-1:0] value;
        logic [TAG_BITS-1:0] tag;
        logic [1:0] msg;
    } coef_item_t;

    typedef struct {
        logic signed [COEF_BITS-1:0] value;
        logic [TAG_BITS-1:0] tag;
        logic changed;
        logic shrunk;
        logic pair_done;
        logic last;
    } embed_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic drv_valid = 1'b0;
    logic signed [COEF_BITS-1:0] drv_value = '0;
    logic [TAG_BITS-1:0] drv_tag = '0;
    logic [1:0] drv_msg = '0;
    logic rcv_ready = 1'b0;

    mes_coef_if #(.COEF_BITS(COEF_BITS), .TAG_BITS(TAG_BITS)) coef_ch ();
    mes_result_if #(.COEF_BITS(COEF_BITS), .TAG_BITS(TAG_BITS)) res_ch ();

    assign coef_ch.valid = drv_valid;
    assign coef_ch.coef_value = drv_value;
    assign coef_ch.coef_tag = drv_tag;
    assign coef_ch.msg_bits = drv_msg;
    assign res_ch.ready = rcv_ready;

    matrix_embed_shrinkage #(.COEF_BITS(COEF_BITS), .TAG_BITS(TAG_BITS)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .coef  (coef_ch),
        .res   (res_ch)
    );

    coef_item_t coef_queue[$];
    embed_result_t embedded_coefs[$];

    logic signed [COEF_BITS-1:0] held_vals[GROUP_SIZE];
    logic [TAG_BITS-1:0] held_tags[GROUP_SIZE];
    int held_count = 0;
    logic [1:0] group_pair = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    int coefs_sent = 0;
    int results_checked = 0;
    int shrinks_seen = 0;
    int changes_seen = 0;
    int pairs_done = 0;
    int errors = 0;

    always #1 clk = ~clk;

    function automatic void push_result(input logic signed [COEF_BITS-1:0] value,
                                        input logic [TAG_BITS-1:0] tag,
                                        input logic changed, input logic shrunk,
                                        input logic pair_done, input logic last);
        embed_result_t r;
        r.value = value;
        r.tag = tag;
        r.changed = changed;
        r.shrunk = shrunk;
        r.pair_done = pair_done;
        r.last = last;
        embedded_coefs.push_back(r);
    endfunction

    function automatic void embed_coef(input coef_item_t item);
        logic [1:0] syndrome;
        logic [1:0] sel;
        int t;
        if (item.value == 0) begin
            push_result(item.value, item.tag, 1'b0, 1'b0, 1'b0, 1'b1);
            return;
        end
        if (held_count == 0)
            group_pair = item.msg;
        held_vals[held_count] = item.value;
        held_tags[held_count] = item.tag;
        held_count++;
        if (held_count < GROUP_SIZE)
            return;

        syndrome = {held_vals[1][0], held_vals[0][0]} ^ {2{held_vals[2][0]}};
        sel = syndrome ^ group_pair;
        t = int'(sel) - 1;
        if (sel != 2'd0) begin
            if (held_vals[t] > 0)
                held_vals[t] = held_vals[t] - COEF_BITS'(1);
            else
                held_vals[t] = held_vals[t] + COEF_BITS'(1);
            if (held_vals[t] == 0) begin
                push_result(held_vals[t], held_tags[t], 1'b1, 1'b1, 1'b0, 1'b1);
                for (int i = t; i < GROUP_SIZE - 1; i++) begin
                    held_vals[i] = held_vals[i + 1];
                    held_tags[i] = held_tags[i + 1];
                end
                held_vals[GROUP_SIZE - 1] = '0;
                held_tags[GROUP_SIZE - 1] = '0;
                held_count = GROUP_SIZE - 1;
                return;
            end
        end
        for (int i = 0; i < GROUP_SIZE; i++)
            push_result(held_vals[i], held_tags[i], (sel != 2'd0) && (i == t), 1'b0,
                        i == GROUP_SIZE - 1, i == GROUP_SIZE - 1);
        held_count = 0;
    endfunction

    function automatic coef_item_t make_coef(input int value, input int tag, input int msg);
        coef_item_t item;
        item.value = COEF_BITS'(value);
        item.tag = TAG_BITS'(tag);
        item.msg = 2'(msg);
        return item;
    endfunction

    function automatic coef_item_t random_coef();
        coef_item_t item;
        int kind;
        int mag;
        kind = $urandom_range(99);
        mag = $urandom_range(3, 1);
        if (kind < 15)
            item.value = '0;
        else if (kind < 65)
            item.value = COEF_BITS'($urandom_range(1) ? -mag : mag);
        else
            item.value = COEF_BITS'($urandom_range(4095));
        item.tag = TAG_BITS'($urandom);
        item.msg = 2'($urandom_range(3));
        return item;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
        end
        else
        begin
            if (drv_valid && coef_ch.ready)
            begin
                embed_coef(make_coef(drv_value, drv_tag, drv_msg));
                coefs_sent++;
            end
            if (!drv_valid || coef_ch.ready)
            begin
                if (coef_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_valid <= 1'b1;
                    drv_value <= coef_queue[0].value;
                    drv_tag <= coef_queue[0].tag;
                    drv_msg <= coef_queue[0].msg;
                    void'(coef_queue.pop_front());
                end
                else
                begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        embed_result_t want;
        if (!rst_n)
        begin
            rcv_ready <= 1'b0;
        end
        else
        begin
            if (res_ch.valid && rcv_ready)
            begin
                if (embedded_coefs.size() == 0)
                begin
                    $error("unexpected result: out_value %0d out_tag 0x%06h",
                           res_ch.out_value, res_ch.out_tag);
                    errors++;
                end
                else
                begin
                    want = embedded_coefs.pop_front();
                    results_checked++;
                    if (want.shrunk)
                        shrinks_seen++;
                    if (want.changed)
                        changes_seen++;
                    if (want.pair_done)
                        pairs_done++;
                    if (res_ch.out_value !== want.value)
                    begin
                        $error("out_value: expected %0d, got %0d", want.value, res_ch.out_value);
                        errors++;
                    end
                    if (res_ch.out_tag !== want.tag)
                    begin
                        $error("out_tag: expected 0x%06h, got 0x%06h", want.tag, res_ch.out_tag);
                        errors++;
                    end
                    if (res_ch.was_changed !== want.changed)
                    begin
                        $error("was_changed: expected %0b, got %0b", want.changed,
                               res_ch.was_changed);
                        errors++;
                    end
                    if (res_ch.shrunk !== want.shrunk)
                    begin
                        $error("shrunk: expected %0b, got %0b", want.shrunk, res_ch.shrunk);
                        errors++;
                    end
                    if (res_ch.pair_done !== want.pair_done)
                    begin
                        $error("pair_done: expected %0b, got %0b", want.pair_done,
                               res_ch.pair_done);
                        errors++;
                    end
                    if (res_ch.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, res_ch.last);
                        errors++;
                    end
                end
            end
            rcv_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The receiver holds off for a fixed stretch each time a hold-off is requested.
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((drv_valid && coef_ch.ready) || (res_ch.valid && rcv_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("matrix_embed_shrinkage verification failed");
                $finish;
            end
        end
    end

    task automatic drain();
        while (coef_queue.size() != 0 || drv_valid || embedded_coefs.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int send_idle, input int recv_stall, input int n_items);
        send_idle_pct = send_idle;
        recv_stall_pct = recv_stall;
        for (int i = 0; i < n_items; i++)
            coef_queue.push_back(random_coef());
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        coef_queue.push_back(make_coef(0, 0, 3));
        coef_queue.push_back(make_coef(0, 24'hFFFFFF, 0));
        coef_queue.push_back(make_coef(1, 24'h000001, 2));
        coef_queue.push_back(make_coef(2, 24'h000002, 0));
        coef_queue.push_back(make_coef(3, 24'h000003, 1));
        coef_queue.push_back(make_coef(1, 24'h100001, 3));
        coef_queue.push_back(make_coef(2, 24'h100002, 0));
        coef_queue.push_back(make_coef(3, 24'h100003, 0));
        coef_queue.push_back(make_coef(0, 24'h5A5A5A, 2));
        coef_queue.push_back(make_coef(-2048, 24'h200000, 1));
        coef_queue.push_back(make_coef(2047, 24'hFFFFFF, 1));
        coef_queue.push_back(make_coef(-1, 24'h300001, 2));
        coef_queue.push_back(make_coef(5, 24'h300002, 0));
        coef_queue.push_back(make_coef(-2048, 24'hA5A5A5, 0));
        coef_queue.push_back(make_coef(-2048, 24'h400002, 3));
        coef_queue.push_back(make_coef(-1, 24'h400003, 3));
        coef_queue.push_back(make_coef(4, 24'h400004, 2));
        coef_queue.push_back(make_coef(-1, 24'h500001, 1));
        coef_queue.push_back(make_coef(6, 24'h500002, 2));
        coef_queue.push_back(make_coef(7, 24'h500003, 3));
        coef_queue.push_back(make_coef(2, 24'h600001, 1));
        coef_queue.push_back(make_coef(-1, 24'h600002, 2));
        coef_queue.push_back(make_coef(1, 24'h600003, 0));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        run_phase(0, 0, 22);
        run_phase(69, 0, 22);
        run_phase(0, 69, 22);
        run_phase(10, 10, 22);

        // The receiver stops while the sender keeps offering, so the job queue fills.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 24; i++)
            coef_queue.push_back(random_coef());
        hold_requests++;
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d coefficients through directed and random phases with idling.",
                 coefs_sent);
        $display("Checked %0d results: %0d changed, %0d shrunk, %0d pairs completed.",
                 results_checked, changes_seen, shrinks_seen, pairs_done);
        if (errors == 0 && embedded_coefs.size() == 0)
            $display("matrix_embed_shrinkage verification clean");
        else
            $display("matrix_embed_shrinkage verification failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/mes_pkg.sv
hdl/mes_coef_if.sv
hdl/mes_result_if.sv
hdl/mes_front.sv
hdl/mes_queue.sv
hdl/mes_back.sv
hdl/matrix_embed_shrinkage.sv
bench/tb_matrix_embed_shrinkage.sv
